// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker files of the core.
// Self-contained: no other file needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CHK_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Same, on the clk / arst_n pair of the block.
`define CHK_ASSERT_CLK(lbl, prop, msg) \
	`CHK_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// ===== rtl/core/flvd_pkg.sv =====
// Package for the FLV tag deframer: constants, parse phase codes and result beat type.
// No dependencies.
`timescale 1ns / 1ps

package flvd_pkg;

	// Default number of lead bytes (file header plus first size field)
	localparam int LEAD_SKIP_DEF = 13;

	localparam int CNT_W = 24;

	// Tag layout
	localparam logic [CNT_W-1:0] HEAD_LEN  = 24'd11;
	localparam logic [CNT_W-1:0] TRAIL_LEN = 24'd4;
	localparam logic [7:0]       TYPE_AUDIO = 8'h08;
	localparam logic [7:0]       TYPE_VIDEO = 8'h09;

	// Header byte positions
	localparam logic [3:0] HB_TYPE   = 4'd0;
	localparam logic [3:0] HB_LEN_2  = 4'd1;
	localparam logic [3:0] HB_LEN_1  = 4'd2;
	localparam logic [3:0] HB_LEN_0  = 4'd3;
	localparam logic [3:0] HB_TIME_2 = 4'd4;
	localparam logic [3:0] HB_TIME_1 = 4'd5;
	localparam logic [3:0] HB_TIME_0 = 4'd6;
	localparam logic [3:0] HB_TIME_X = 4'd7;

	// Parse phases
	localparam logic [1:0] PH_LEAD  = 2'd0;
	localparam logic [1:0] PH_HEAD  = 2'd1;
	localparam logic [1:0] PH_BODY  = 2'd2;
	localparam logic [1:0] PH_TRAIL = 2'd3;

	typedef struct packed {
		logic [7:0]  body_byte;
		logic        is_video;
		logic [31:0] tag_time;
		logic [23:0] tag_length;
		logic        first_of_tag;
		logic        last_of_tag;
		logic        empty_tag;
	} res_t;

endpackage

// ===== rtl/core/flv_tag_deframer.sv =====
// FLV tag deframer top level: byte parser, result register and skid register.
// Depends on flvd_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: data_byte with in_valid / in_stall, one raw FLV byte a beat.
//   Output channel: body_byte plus tag fields with out_valid / out_stall.
//   The first LEAD_SKIP_BYTES bytes (file header, first size field) are
//   dropped. Each tag header is parsed; bodies of audio and video tags come
//   out one byte a beat with first/last marks; an empty audio or video tag
//   gives a single beat with empty_tag set. Other tags and the four-byte
//   size field after every tag give no beats.
//   Throughput: one input byte a cycle while in_stall is low, set by the
//   combinational parse step between the parse state and the result register.
//   A result beat is registered in the output register, or in the skid
//   register while the output is stalled, when its byte is taken.
//   Reset: arst_n clears the parser to the lead-skip phase (the header
//   phase when LEAD_SKIP_BYTES is 0) and empties the output and skid registers.
//   Stall: while out_stall holds, one more result is kept in the skid
//   register; in_stall rises (registered) only once that is full and falls
//   the cycle after the output moves again.
module flv_tag_deframer
	import flvd_pkg::*;
#(
	parameter int LEAD_SKIP_BYTES = LEAD_SKIP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [7:0]  body_byte,
	output logic        is_video,
	output logic [31:0] tag_time,
	output logic [23:0] tag_length,
	output logic        first_of_tag,
	output logic        last_of_tag,
	output logic        empty_tag,
	output logic        out_valid,
	input  logic        out_stall
);

	localparam logic [1:0]       PH_RESET = (LEAD_SKIP_BYTES == 0) ? PH_HEAD : PH_LEAD;
	localparam logic [CNT_W-1:0] LEAD_LEN = CNT_W'(LEAD_SKIP_BYTES);

	logic [1:0]       phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic [7:0]       type_q, type_d;
	logic [23:0]      len_q, len_d;
	logic [31:0]      time_q, time_d;
	logic             acc_q, acc_d;

	logic res_v;
	res_t res;

	res_t out_q, skid_q;
	logic out_v_q, skid_v_q;

	logic take, pop, push;

	assign take    = in_valid && !in_stall;
	assign cnt_inc = cnt_q + CNT_W'(1);

	// Parse one byte: advance phase and count, capture header fields
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_inc;
		type_d  = type_q;
		len_d   = len_q;
		time_d  = time_q;
		acc_d   = acc_q;
		res_v   = 1'b0;
		res.body_byte    = data_byte;
		res.is_video     = (type_q == TYPE_VIDEO);
		res.tag_time     = time_q;
		res.tag_length   = len_q;
		res.first_of_tag = 1'b0;
		res.last_of_tag  = 1'b0;
		res.empty_tag    = 1'b0;
		case (phase_q)
			PH_LEAD: begin
				if (cnt_inc >= LEAD_LEN) begin
					phase_d = PH_HEAD;
					cnt_d   = '0;
				end
			end
			PH_HEAD: begin
				case (cnt_q[3:0])
					HB_TYPE:   type_d = data_byte;
					HB_LEN_2:  len_d  = {data_byte, 16'h0000};
					HB_LEN_1:  len_d  = {len_q[23:16], data_byte, 8'h00};
					HB_LEN_0:  len_d  = {len_q[23:8], data_byte};
					HB_TIME_2: time_d = {8'h00, data_byte, 16'h0000};
					HB_TIME_1: time_d = {time_q[31:16], data_byte, 8'h00};
					HB_TIME_0: time_d = {time_q[31:8], data_byte};
					HB_TIME_X: time_d = {data_byte, time_q[23:0]};
					default: begin
					end
				endcase
				// Last header byte: decide whether this tag is passed on
				if (cnt_inc >= HEAD_LEN) begin
					acc_d = (type_q == TYPE_AUDIO) || (type_q == TYPE_VIDEO);
					cnt_d = '0;
					if (len_q == '0) begin
						phase_d = PH_TRAIL;
						if (acc_d) begin
							res_v            = 1'b1;
							res.body_byte    = 8'h00;
							res.first_of_tag = 1'b1;
							res.last_of_tag  = 1'b1;
							res.empty_tag    = 1'b1;
						end
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				res_v            = acc_q;
				res.first_of_tag = (cnt_q == '0);
				res.last_of_tag  = (cnt_inc >= len_q);
				if (cnt_inc >= len_q) begin
					phase_d = PH_TRAIL;
					cnt_d   = '0;
				end
			end
			default: begin
				if (cnt_inc >= TRAIL_LEN) begin
					phase_d = PH_HEAD;
					cnt_d   = '0;
				end
			end
		endcase
	end

	// Hold parse state; advance on each taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RESET;
			cnt_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			time_q  <= '0;
			acc_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			type_q  <= type_d;
			len_q   <= len_d;
			time_q  <= time_d;
			acc_q   <= acc_d;
		end
	end

	assign pop  = out_v_q && !out_stall;
	assign push = take && res_v;

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (pop || !out_v_q) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload moves without reset
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (pop || !out_v_q) begin
			if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign in_stall     = skid_v_q;
	assign out_valid    = out_v_q;
	assign body_byte    = out_q.body_byte;
	assign is_video     = out_q.is_video;
	assign tag_time     = out_q.tag_time;
	assign tag_length   = out_q.tag_length;
	assign first_of_tag = out_q.first_of_tag;
	assign last_of_tag  = out_q.last_of_tag;
	assign empty_tag    = out_q.empty_tag;

endmodule

// ===== rtl/core/flvd_chk.sv =====
// Port-level checker for the FLV tag deframer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flvd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic [7:0]  body_byte,
	input logic        first_of_tag,
	input logic        last_of_tag,
	input logic        empty_tag,
	input logic        out_valid,
	input logic        out_stall
);

	// Input stalls only while a result is held on the output
	`CHK_ASSERT_CLK(a_stall_needs_out, in_stall |-> out_valid, "in_stall without out_valid")

	// Input stall only rises after the output was stalled
	`CHK_ASSERT_CLK(a_stall_cause, $rose(in_stall) |-> $past(out_valid && out_stall), "in_stall rose without output stall")

	// Empty marker is a whole tag with a zero byte
	`CHK_ASSERT_CLK(a_empty_beat, (out_valid && empty_tag) |-> (first_of_tag && last_of_tag && body_byte == 8'h00), "malformed empty beat")

	// A stalled result beat stays valid
	`CHK_ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> out_valid, "stalled output dropped")

endmodule

bind flv_tag_deframer flvd_chk u_flvd_chk (.*);
